>>> rtl/iee_pkg.sv
// Shared types and character codes for the infix expression evaluator.
package iee_pkg;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = $clog2(DataW);

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } term_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_char;   // capture the accepted character
    logic num_step;    // feed a non-operator, non-space character to the operand reader
    logic close_num;   // fold the operand into the term (start divider if needed)
    logic div_step;    // one restoring division step
    logic div_finish;  // write the signed quotient into the term
    logic close_term;  // add or subtract the term into the sum
    logic set_op;      // record the operator of the current character
    logic emit;        // load the result register and clear the state
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_space;
    logic is_addsub;
    logic is_muldiv;
    logic last;
    logic div_needed;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/iee_ctrl.sv
// Sequencing state machine of the infix expression evaluator.
module iee_ctrl import iee_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CHAR = 7'b0000010,
    S_NUM  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_FIN  = 7'b0010000,
    S_POST = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   final_q, final_d;

  always_comb begin
    state_d    = state_q;
    final_d    = final_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_char = 1'b1;
          state_d         = S_CHAR;
        end
      end
      S_CHAR: begin
        if (sts_i.is_addsub || sts_i.is_muldiv) begin
          final_d = 1'b0;
          state_d = S_NUM;
        end else begin
          cmd_o.num_step = !sts_i.is_space;
          final_d        = sts_i.last;
          state_d        = sts_i.last ? S_NUM : S_IDLE;
        end
      end
      S_NUM: begin
        cmd_o.close_num = 1'b1;
        state_d         = sts_i.div_needed ? S_DIV : S_POST;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.div_finish = 1'b1;
        state_d          = S_POST;
      end
      S_POST: begin
        if (final_q) begin
          cmd_o.close_term = 1'b1;
          state_d          = S_EMIT;
        end else begin
          cmd_o.close_term = sts_i.is_addsub;
          cmd_o.set_op     = 1'b1;
          final_d          = sts_i.last;
          state_d          = sts_i.last ? S_NUM : S_IDLE;
        end
      end
      S_EMIT: begin
        // hold until the result register can take the value
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          final_d    = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        final_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      final_q <= final_d;
    end
  end

endmodule

>>> rtl/iee_dp.sv
// Accumulators, operand reader, multiplier, iterative divider and result register.
module iee_dp import iee_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       ch_i,
  input  logic             last_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] out_value_o,
  output logic             out_err_o
);

  logic [7:0]       ch_q;
  logic             last_q;
  logic [DataW-1:0] sum_q, sum_d;
  logic [DataW-1:0] term_q, term_d;
  term_op_e         op_q, op_d;
  logic             neg_q, neg_d;
  logic [DataW-1:0] num_q, num_d;
  logic             started_q, started_d;
  logic             ended_q, ended_d;
  logic             err_q, err_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             qneg_q, qneg_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_value_q, out_value_d;
  logic             out_err_q, out_err_d;

  logic             is_digit, is_ws;
  logic [DataW-1:0] num_x10;
  logic [DataW-1:0] product;
  logic [DataW:0]   rem_sh, diff;
  logic             out_free;

  assign is_digit = ch_q inside {[ChZero:ChNine]};
  assign is_ws    = ch_q inside {[ChTab:ChCr]};
  assign num_x10  = (num_q << 3) + (num_q << 1);
  assign product  = term_q * num_q;
  assign rem_sh   = {rem_q, quo_q[DataW-1]};
  assign diff     = rem_sh - {1'b0, dvs_q};
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.is_space   = (ch_q == ChSpace);
    sts_o.is_addsub  = (ch_q == ChPlus) || (ch_q == ChMinus);
    sts_o.is_muldiv  = (ch_q == ChStar) || (ch_q == ChSlash);
    sts_o.last       = last_q;
    sts_o.div_needed = (op_q == OP_DIV) && (num_q != '0);
    sts_o.div_done   = (cnt_q == CntW'(DataW - 1));
    sts_o.out_free   = out_free;
  end

  always_comb begin
    sum_d       = sum_q;
    term_d      = term_q;
    op_d        = op_q;
    neg_d       = neg_q;
    num_d       = num_q;
    started_d   = started_q;
    ended_d     = ended_q;
    err_d       = err_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dvs_d       = dvs_q;
    cnt_d       = cnt_q;
    qneg_d      = qneg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    out_err_d   = out_err_q;

    if (cmd_i.num_step && !ended_q) begin
      if (is_digit) begin
        num_d     = num_x10 + DataW'(ch_q - ChZero);
        started_d = 1'b1;
      end else if (!(is_ws && !started_q)) begin
        started_d = 1'b1;
        ended_d   = 1'b1;
      end
    end

    if (cmd_i.close_num) begin
      case (op_q)
        OP_MUL: term_d = product;
        OP_DIV: begin
          if (num_q == '0) begin
            err_d  = 1'b1;
            term_d = '0;
          end else begin
            // divide magnitudes, fix the sign at the end
            rem_d  = '0;
            quo_d  = term_q[DataW-1] ? (DataW'(0) - term_q) : term_q;
            dvs_d  = num_q[DataW-1] ? (DataW'(0) - num_q) : num_q;
            cnt_d  = '0;
            qneg_d = term_q[DataW-1] ^ num_q[DataW-1];
          end
        end
        default: term_d = num_q;
      endcase
      op_d      = OP_NONE;
      num_d     = '0;
      started_d = 1'b0;
      ended_d   = 1'b0;
    end

    if (cmd_i.div_step) begin
      if (!diff[DataW]) begin
        rem_d = diff[DataW-1:0];
      end else begin
        rem_d = rem_sh[DataW-1:0];
      end
      quo_d = {quo_q[DataW-2:0], ~diff[DataW]};
      cnt_d = cnt_q + CntW'(1);
    end

    if (cmd_i.div_finish) begin
      term_d = qneg_q ? (DataW'(0) - quo_q) : quo_q;
    end

    if (cmd_i.close_term) begin
      sum_d  = sum_q + (neg_q ? (DataW'(0) - term_q) : term_q);
      term_d = '0;
      neg_d  = 1'b0;
    end

    if (cmd_i.set_op) begin
      case (ch_q)
        ChMinus: neg_d = 1'b1;
        ChPlus:  neg_d = 1'b0;
        ChStar:  op_d  = OP_MUL;
        ChSlash: op_d  = OP_DIV;
        default: op_d  = op_q;
      endcase
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_value_d = err_q ? '0 : sum_q;
      out_err_d   = err_q;
      sum_d       = '0;
      term_d      = '0;
      op_d        = OP_NONE;
      neg_d       = 1'b0;
      num_d       = '0;
      started_d   = 1'b0;
      ended_d     = 1'b0;
      err_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      term_q      <= '0;
      op_q        <= OP_NONE;
      neg_q       <= 1'b0;
      num_q       <= '0;
      started_q   <= 1'b0;
      ended_q     <= 1'b0;
      err_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      term_q      <= term_d;
      op_q        <= op_d;
      neg_q       <= neg_d;
      num_q       <= num_d;
      started_q   <= started_d;
      ended_q     <= ended_d;
      err_q       <= err_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_char) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    dvs_q       <= dvs_d;
    qneg_q      <= qneg_d;
    out_value_q <= out_value_d;
    out_err_q   <= out_err_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_err_o   = out_err_q;

endmodule

>>> rtl/infix_expression_evaluator.sv
// Top level of the streaming infix expression evaluator (+ - * / on 32-bit integers).
//
//   channel   direction  tdata                    tlast             tuser
//   s_axis    in         [7:0] ch (ASCII)         last character    -
//   m_axis    out        [31:0] value (signed)    -                 div_by_zero
//
// A space or operand character is accepted and then decoded.
// An operator is accepted, decoded, folds the operand and applies the operator.
// A divide with a nonzero divisor also runs the restoring divider, which
// retires one quotient bit per cycle, and then applies the sign.
// The last character also folds the final operand and term and loads the
// result register.
// Reset clears all accumulators; no clearing pass is needed.
// A result waits in the output register; the next expression is accepted
// meanwhile and stalls only if its own result is ready before the old one
// is taken.
module infix_expression_evaluator import iee_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] value
  output logic        m_axis_tuser_o    // [0] div_by_zero
);

  cmd_t cmd;
  sts_t sts;

  // Controller: walks each character through decode, fold, divide and emit.
  iee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: holds the sum, term and operand, and the output register.
  iee_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ch_i        (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_value_o (m_axis_tdata_o),
    .out_err_o   (m_axis_tuser_o)
  );

endmodule

>>> dv/tb_infix_expression_evaluator.sv
// Self-checking testbench for the streaming infix expression evaluator.
`timescale 1ns / 1ps

module tb_infix_expression_evaluator;
  import iee_pkg::*;

  // What the sender queue can hold besides plain characters.
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,  // one character transaction
    KIND_GAP   = 2'd1,  // idle gap: hold tvalid low, its length given by count
    KIND_DRAIN = 2'd2,  // hold off until every expected result has come back
    KIND_CALM  = 2'd3   // stop all idling on both sides from here on
  } text_kind_e;

  typedef struct packed {
    text_kind_e  kind;
    logic [7:0]  ch;
    logic        fin;
    logic [4:0]  count;
  } text_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        div_by_zero;
  } eval_result_t;

  logic        clk;
  logic        rst_n = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  text_item_t   text_q[$];            // pending sender work, filled up front
  logic [7:0]   expr_b[$];            // expression under construction
  eval_result_t expected_results[$];  // values still owed by the block

  // Evaluator mirror: accumulators of the expression being streamed in.
  logic [31:0] p_sum     = '0;
  logic [31:0] p_term    = '0;
  logic [31:0] p_num     = '0;
  term_op_e    p_op      = OP_NONE;
  logic        p_neg     = 1'b0;
  logic        p_started = 1'b0;
  logic        p_ended   = 1'b0;
  logic        p_div0    = 1'b0;

  int unsigned predicted_cnt = 0;
  int unsigned checked_cnt   = 0;
  int unsigned zero_div_cnt  = 0;
  int unsigned chars_sent    = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned queued_chars  = 0;
  int unsigned gap_left      = 0;
  int unsigned stall_left    = 0;
  logic        calm_phase    = 1'b0;
  bit          no_gaps       = 1'b0;

  infix_expression_evaluator uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Evaluator mirror
  // ---------------------------------------------------------------------------

  // Fold the finished operand into the running term.
  task automatic fold_operand();
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] quo;
    case (p_op)
      OP_MUL: p_term = p_term * p_num;
      OP_DIV: begin
        if (p_num == 32'd0) begin
          p_div0 = 1'b1;
          p_term = 32'd0;
        end else begin
          // Divide magnitudes, then restore the sign: truncation toward zero,
          // and the most negative value over -1 wraps back onto itself.
          mag_a  = p_term[31] ? -p_term : p_term;
          mag_b  = p_num[31] ? -p_num : p_num;
          quo    = mag_a / mag_b;
          p_term = (p_term[31] ^ p_num[31]) ? -quo : quo;
        end
      end
      default: p_term = p_num;
    endcase
    p_op      = OP_NONE;
    p_num     = 32'd0;
    p_started = 1'b0;
    p_ended   = 1'b0;
  endtask

  // Add or subtract the finished term into the sum.
  task automatic fold_term();
    p_sum  = p_sum + (p_neg ? -p_term : p_term);
    p_term = 32'd0;
    p_neg  = 1'b0;
  endtask

  // Advance the mirror by one accepted character; queue the value on the last.
  task automatic eval_char(input logic [7:0] c, input logic fin);
    if (c == ChSpace) begin
      // spaces vanish, even inside a number
    end else if (c == ChPlus || c == ChMinus) begin
      fold_operand();
      fold_term();
      p_neg = (c == ChMinus);
    end else if (c == ChStar || c == ChSlash) begin
      fold_operand();
      p_op = (c == ChStar) ? OP_MUL : OP_DIV;
    end else if (!p_ended) begin
      if (c >= ChZero && c <= ChNine) begin
        p_num     = p_num * 32'd10 + 32'(c - ChZero);
        p_started = 1'b1;
      end else if (!p_started && c >= ChTab && c <= ChCr) begin
        // leading whitespace before the first digit
      end else begin
        // any other byte ends the operand; the rest up to an operator is dropped
        p_started = 1'b1;
        p_ended   = 1'b1;
      end
    end
    if (fin) begin
      fold_operand();
      fold_term();
      expected_results.push_back('{value: p_div0 ? 32'd0 : p_sum, div_by_zero: p_div0});
      predicted_cnt++;
      p_sum  = 32'd0;
      p_term = 32'd0;
      p_op   = OP_NONE;
      p_neg  = 1'b0;
      p_div0 = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t ERROR %s: expected 0x%08h, got 0x%08h", $time, what, want, got);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Expression builders
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0:       return ChPlus;
      1:       return ChMinus;
      2:       return ChStar;
      default: return ChSlash;
    endcase
  endfunction

  // Random byte that is neither an operator nor a space.
  function automatic logic [7:0] junk_byte(input bit allow_digit);
    logic [7:0] b;
    do
      b = 8'($urandom_range(0, 255));
    while (b == ChSpace || b == ChPlus || b == ChMinus || b == ChStar || b == ChSlash ||
           (!allow_digit && b >= ChZero && b <= ChNine));
    return b;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) expr_b.push_back(s[i]);
  endtask

  // Turn the built expression into character transactions, sprinkling idle gaps.
  task automatic send_expr();
    if (expr_b.size() == 0) expr_b.push_back(ChZero);
    for (int i = 0; i < expr_b.size(); i++) begin
      if (!no_gaps && $urandom_range(0, 5) == 0)
        text_q.push_back('{kind: KIND_GAP, ch: 8'h00, fin: 1'b0,
                           count: 5'($urandom_range(1, 18))});
      text_q.push_back('{kind: KIND_CHAR, ch: expr_b[i], fin: (i == expr_b.size() - 1),
                         count: 5'd0});
    end
    queued_chars += expr_b.size();
    expr_b.delete();
  endtask

  task automatic add_operand();
    longint unsigned n;
    string           s;
    n = 0;
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 2))
        expr_b.push_back(($urandom_range(0, 5) == 0) ? ChSpace : 8'($urandom_range(9, 13)));
    case ($urandom_range(0, 9))
      0: s = "";
      1: begin
        case ($urandom_range(0, 6))
          0: n = 64'd0;
          1: n = 64'd1;
          2: n = 64'd2147483647;
          3: n = 64'd2147483648;
          4: n = 64'd4294967295;
          5: n = 64'd4294967296;   // wraps to zero
          default: n = 64'd99999999999;
        endcase
        s = $sformatf("%0d", n);
      end
      2, 3: s = $sformatf("%0d", $urandom);
      default: s = $sformatf("%0d", $urandom_range(0, 999));
    endcase
    for (int i = 0; i < s.len(); i++) begin
      expr_b.push_back(s[i]);
      if ($urandom_range(0, 15) == 0) expr_b.push_back(ChSpace);
    end
    // trailing junk ends the operand; whatever follows it is ignored
    if ($urandom_range(0, 7) == 0) begin
      expr_b.push_back(junk_byte(1'b0));
      repeat ($urandom_range(0, 2)) expr_b.push_back(junk_byte(1'b1));
    end
  endtask

  task automatic build_expression();
    if ($urandom_range(0, 9) < 2) begin
      // raw noise over the whole byte range
      repeat ($urandom_range(1, 12)) expr_b.push_back(8'($urandom_range(0, 255)));
    end else begin
      // most negative value over minus one
      if ($urandom_range(0, 29) == 0) add_text("2147483648/4294967295+");
      if ($urandom_range(0, 7) == 0) expr_b.push_back(pick_op());
      add_operand();
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 3) == 0) expr_b.push_back(ChSpace);
        expr_b.push_back(pick_op());
        if ($urandom_range(0, 15) == 0) expr_b.push_back(pick_op());
        if ($urandom_range(0, 3) == 0) expr_b.push_back(ChSpace);
        add_operand();
      end
      if ($urandom_range(0, 11) == 0) expr_b.push_back(pick_op());
    end
    send_expr();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one transaction per queue entry, gaps and drains in between
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : driver
    text_item_t head;
    logic       fire;
    if (!rst_n) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) begin
        eval_char(s_axis_tdata, s_axis_tlast);
        chars_sent <= chars_sent + 1;
      end
      // A character still waiting for tready keeps its data and valid.
      if (!s_axis_tvalid || fire) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (text_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          head = text_q[0];
          s_axis_tvalid <= (head.kind == KIND_CHAR);
          case (head.kind)
            KIND_GAP: begin
              gap_left = head.count - 1;
              void'(text_q.pop_front());
            end
            KIND_DRAIN: begin
              if (checked_cnt >= predicted_cnt) void'(text_q.pop_front());
            end
            KIND_CALM: begin
              calm_phase <= 1'b1;
              void'(text_q.pop_front());
            end
            default: begin
              s_axis_tdata <= head.ch;
              s_axis_tlast <= head.fin;
              void'(text_q.pop_front());
            end
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result against the oldest expectation, stall at random
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : monitor
    eval_result_t want;
    if (!rst_n) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with none outstanding", 32'd0, m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata !== want.value)
            report_mismatch("value", want.value, m_axis_tdata);
          if (m_axis_tuser !== want.div_by_zero)
            report_mismatch("div_by_zero", 32'(want.div_by_zero), 32'(m_axis_tuser));
        end
        checked_cnt <= checked_cnt + 1;
        if (m_axis_tuser) zero_div_cnt <= zero_div_cnt + 1;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 17);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned rand_start;
    bit          mid_drain_done;
    mid_drain_done = 1'b0;

    // Directed: leading minus, trailing multiply, trailing divide, then a mix of
    // leading tab, a space inside a number, junk ending an operand, all operators;
    // then a lone NUL and the top byte value.
    add_text("-5");
    send_expr();
    add_text("3*");
    send_expr();
    add_text("8/");
    send_expr();
    add_text("\t12 3x9+7/2*3-1");
    send_expr();
    expr_b.push_back(8'h00);
    send_expr();
    add_text("9");
    expr_b.push_back(8'hFF);
    send_expr();
    // Hold the sender until the block has handed back everything.
    text_q.push_back('{kind: KIND_DRAIN, ch: 8'h00, fin: 1'b0, count: 5'd0});

    rand_start = queued_chars;
    while (queued_chars - rand_start < 1750) begin
      if (!mid_drain_done && queued_chars - rand_start >= 800) begin
        text_q.push_back('{kind: KIND_DRAIN, ch: 8'h00, fin: 1'b0, count: 5'd0});
        mid_drain_done = 1'b1;
      end
      if (!no_gaps && queued_chars - rand_start >= 1500) begin
        text_q.push_back('{kind: KIND_CALM, ch: 8'h00, fin: 1'b0, count: 5'd0});
        no_gaps = 1'b1;
      end
      build_expression();
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait for the sender to empty and every value to come back.
    while (text_q.size() != 0 || s_axis_tvalid || checked_cnt < predicted_cnt)
      @(posedge clk);
    // Give a stray result time to show up.
    repeat (60) @(posedge clk);

    $display("covered %0d characters in %0d expressions, %0d with a zero divisor",
             chars_sent, checked_cnt, zero_div_cnt);
    if (mismatch_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d of %0d results checked", checked_cnt, predicted_cnt);
    $display("tb: failure");
    $finish;
  end

endmodule
